### design/rpa_pkg.sv
// Shared constants and codes of the reference-counted page allocator.
package rpa_pkg;

    // Default sizing
    localparam int PAGE_COUNT_DEF = 16384;
    localparam int REF_WIDTH_DEF  = 8;

    // Address layout
    localparam int PAGE_SHIFT = 12;
    localparam int ADDR_W     = 32;
    localparam int CFG_W      = 27;
    localparam int PA_W       = 26;
    localparam int CNT_OUT_W  = 8;

    // Configuration register indexes
    localparam logic CFG_KERNEL_END = 1'b0;
    localparam logic CFG_PHYS_TOP   = 1'b1;

    // Configuration reset values
    localparam logic [CFG_W-1:0] KERNEL_END_RST = 27'd0;
    localparam logic [CFG_W-1:0] PHYS_TOP_RST   = 27'd67108864;

    // Operation codes
    localparam logic [2:0] OP_ALLOC  = 3'd0;
    localparam logic [2:0] OP_FREE   = 3'd1;
    localparam logic [2:0] OP_INCREF = 3'd2;
    localparam logic [2:0] OP_DECREF = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_MISALIGNED = 3'd1;
    localparam logic [2:0] ST_RANGE      = 3'd2;
    localparam logic [2:0] ST_UNDERFLOW  = 3'd3;
    localparam logic [2:0] ST_EMPTY      = 3'd4;
    localparam logic [2:0] ST_SATURATED  = 3'd5;

endpackage

### design/refcounted_page_allocator.sv
// Top level of the reference-counted page allocator: control, free stack and count store.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------------
//  s_       | in        | s_valid / s_ready  | s_opcode, s_address
//  m_       | out       | m_valid / m_ready  | m_status, m_page_address, m_ref_count,
//           |           |                    | m_page_freed
//  cfg_     | in        | cfg_wr_en          | cfg_index, cfg_wr_data
//
// An item is accepted in S_IDLE, which issues reads of the count RAM and the
// free-stack RAM; in S_EXEC the item is modified, written back and loaded into
// the result register. The count RAM's single read-modify-write is why no new item is taken until S_EXEC is done.
// After reset the count RAM is cleared one entry a cycle, over every entry,
// with s_ready low; configuration writes are taken throughout.
// A result not yet taken holds the item in S_EXEC until m_ready.
module refcounted_page_allocator #(
    parameter int PAGE_COUNT = rpa_pkg::PAGE_COUNT_DEF,
    parameter int REF_WIDTH  = rpa_pkg::REF_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_wr_en,
    input  logic                      cfg_index,
    input  logic [rpa_pkg::CFG_W-1:0] cfg_wr_data,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                s_opcode,
    input  logic [rpa_pkg::ADDR_W-1:0] s_address,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_status,
    output logic [rpa_pkg::PA_W-1:0]  m_page_address,
    output logic [rpa_pkg::CNT_OUT_W-1:0] m_ref_count,
    output logic                      m_page_freed
);

    localparam int IDX_W   = $clog2(PAGE_COUNT);
    localparam int DEPTH_W = $clog2(PAGE_COUNT + 1);
    localparam int PN_W    = rpa_pkg::ADDR_W - rpa_pkg::PAGE_SHIFT;
    localparam int FULLPA_W = IDX_W + rpa_pkg::PAGE_SHIFT;
    localparam logic [REF_WIDTH-1:0] REF_MAX = '1;
    localparam logic [REF_WIDTH-1:0] REF_ONE = REF_WIDTH'(1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                        state_reg;
    logic [IDX_W-1:0]              clr_cnt_reg;
    logic [DEPTH_W-1:0]            depth_reg;
    logic [rpa_pkg::CFG_W-1:0]     kend_reg;
    logic [rpa_pkg::CFG_W-1:0]     ptop_reg;
    logic [2:0]                    op_reg;
    logic [rpa_pkg::ADDR_W-1:0]    addr_reg;
    logic                          m_valid_reg;
    logic [2:0]                    status_reg;
    logic [rpa_pkg::PA_W-1:0]      pa_reg;
    logic [rpa_pkg::CNT_OUT_W-1:0] cnt_out_reg;
    logic                          freed_reg;

    logic                          accept;
    logic                          exec_fire;
    logic [IDX_W-1:0]              page_idx;
    logic [REF_WIDTH-1:0]          cnt;
    logic [IDX_W-1:0]              stack_top;
    logic                          in_range;
    logic                          misaligned;
    logic                          below_kend;
    logic                          stack_full;
    logic [FULLPA_W-1:0]           pa_full;

    logic [2:0]                    res_status;
    logic [rpa_pkg::PA_W-1:0]      res_pa;
    logic [REF_WIDTH-1:0]          res_cnt;
    logic                          res_freed;
    logic                          ref_we;
    logic [REF_WIDTH-1:0]          ref_wdata;
    logic                          push;
    logic                          pop;

    logic                          ram_ref_we;
    logic [IDX_W-1:0]              ram_ref_waddr;
    logic [REF_WIDTH-1:0]          ram_ref_wdata;

    // Handshakes
    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign exec_fire = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);

    // Decode the registered address
    assign page_idx   = addr_reg[rpa_pkg::PAGE_SHIFT +: IDX_W];
    assign in_range   = (addr_reg < {{(rpa_pkg::ADDR_W - rpa_pkg::CFG_W){1'b0}}, ptop_reg})
                     && ({1'b0, addr_reg[rpa_pkg::ADDR_W-1:rpa_pkg::PAGE_SHIFT]}
                         < (PN_W + 1)'(PAGE_COUNT));
    assign misaligned = |addr_reg[rpa_pkg::PAGE_SHIFT-1:0];
    assign below_kend = addr_reg < {{(rpa_pkg::ADDR_W - rpa_pkg::CFG_W){1'b0}}, kend_reg};
    assign stack_full = (depth_reg == DEPTH_W'(PAGE_COUNT));
    assign pa_full    = {stack_top, {rpa_pkg::PAGE_SHIFT{1'b0}}};

    // Work out the result and the write-backs of one item
    always_comb begin
        res_status = rpa_pkg::ST_OK;
        res_pa     = '0;
        res_cnt    = '0;
        res_freed  = 1'b0;
        ref_we     = 1'b0;
        ref_wdata  = cnt;
        push       = 1'b0;
        pop        = 1'b0;
        if (op_reg == rpa_pkg::OP_ALLOC) begin
            if (depth_reg == '0) begin
                res_status = rpa_pkg::ST_EMPTY;
            end else begin
                pop       = 1'b1;
                ref_we    = 1'b1;
                ref_wdata = REF_ONE;
                res_pa    = rpa_pkg::PA_W'(pa_full);
                res_cnt   = REF_ONE;
            end
        end else if (op_reg > rpa_pkg::OP_QUERY) begin
            res_status = rpa_pkg::ST_OK;
        end else if (!in_range) begin
            res_status = rpa_pkg::ST_RANGE;
        end else begin
            case (op_reg)
                rpa_pkg::OP_FREE: begin
                    res_cnt = cnt;
                    if (misaligned) begin
                        res_status = rpa_pkg::ST_MISALIGNED;
                    end else if (below_kend) begin
                        res_status = rpa_pkg::ST_RANGE;
                    end else if (cnt > REF_ONE) begin
                        ref_we    = 1'b1;
                        ref_wdata = cnt - 1'b1;
                        res_cnt   = cnt - 1'b1;
                    end else if (!stack_full) begin
                        push      = 1'b1;
                        res_freed = 1'b1;
                    end else begin
                        res_status = rpa_pkg::ST_SATURATED;
                    end
                end
                rpa_pkg::OP_INCREF: begin
                    res_cnt = cnt;
                    if (cnt == REF_MAX) begin
                        res_status = rpa_pkg::ST_SATURATED;
                    end else begin
                        ref_we    = 1'b1;
                        ref_wdata = cnt + 1'b1;
                        res_cnt   = cnt + 1'b1;
                    end
                end
                rpa_pkg::OP_DECREF: begin
                    if (cnt == '0) begin
                        res_status = rpa_pkg::ST_UNDERFLOW;
                    end else begin
                        ref_we    = 1'b1;
                        ref_wdata = cnt - 1'b1;
                        res_cnt   = cnt - 1'b1;
                        if (cnt != REF_ONE) begin
                            res_status = rpa_pkg::ST_OK;
                        end else if (misaligned) begin
                            res_status = rpa_pkg::ST_MISALIGNED;
                        end else if (below_kend) begin
                            res_status = rpa_pkg::ST_RANGE;
                        end else if (!stack_full) begin
                            push      = 1'b1;
                            res_freed = 1'b1;
                        end else begin
                            res_status = rpa_pkg::ST_SATURATED;
                        end
                    end
                end
                default: begin
                    res_cnt = cnt;
                end
            endcase
        end
    end

    // Count RAM write port: clearing pass or item write-back
    always_comb begin
        if (state_reg == S_CLEAR) begin
            ram_ref_we    = 1'b1;
            ram_ref_waddr = clr_cnt_reg;
            ram_ref_wdata = '0;
        end else begin
            ram_ref_we    = exec_fire && ref_we;
            ram_ref_waddr = pop ? stack_top : page_idx;
            ram_ref_wdata = ref_wdata;
        end
    end

    rpa_ram #(
        .WIDTH (REF_WIDTH),
        .DEPTH (PAGE_COUNT)
    ) u_ref_ram (
        .aclk    (aclk),
        .wr_en   (ram_ref_we),
        .wr_addr (ram_ref_waddr),
        .wr_data (ram_ref_wdata),
        .rd_en   (accept),
        .rd_addr (s_address[rpa_pkg::PAGE_SHIFT +: IDX_W]),
        .rd_data (cnt)
    );

    rpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (PAGE_COUNT)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (exec_fire && push),
        .wr_addr (depth_reg[IDX_W-1:0]),
        .wr_data (page_idx),
        .rd_en   (accept),
        .rd_addr (IDX_W'(depth_reg - 1'b1)),
        .rd_data (stack_top)
    );

    // Sequencer, stack depth, configuration and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            depth_reg   <= '0;
            kend_reg    <= rpa_pkg::KERNEL_END_RST;
            ptop_reg    <= rpa_pkg::PHYS_TOP_RST;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    rpa_pkg::CFG_KERNEL_END: kend_reg <= cfg_wr_data;
                    rpa_pkg::CFG_PHYS_TOP:   ptop_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            // Drop a taken result unless a new one loads now
            if (m_ready && !exec_fire) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == IDX_W'(PAGE_COUNT - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        op_reg    <= s_opcode;
                        addr_reg  <= s_address;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_fire) begin
                        if (pop) begin
                            depth_reg <= depth_reg - 1'b1;
                        end else if (push) begin
                            depth_reg <= depth_reg + 1'b1;
                        end
                        m_valid_reg <= 1'b1;
                        status_reg  <= res_status;
                        pa_reg      <= res_pa;
                        cnt_out_reg <= rpa_pkg::CNT_OUT_W'(res_cnt);
                        freed_reg   <= res_freed;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_page_address = pa_reg;
    assign m_ref_count    = cnt_out_reg;
    assign m_page_freed   = freed_reg;

endmodule

### design/rpa_ram.sv
// Simple dual-port synchronous RAM with registered, enable-held read data.
module rpa_ram #(
    parameter int WIDTH = rpa_pkg::REF_WIDTH_DEF,
    parameter int DEPTH = rpa_pkg::PAGE_COUNT_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port: hold the last word until the next enabled read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### dv/refcounted_page_allocator_test.sv
// Self-checking testbench for the reference-counted page allocator.
module refcounted_page_allocator_test;

    localparam int NUM_PAGES  = rpa_pkg::PAGE_COUNT_DEF;
    localparam int POOL_SIZE  = 12;
    localparam int CYCLE_CAP  = 1000000;
    localparam int ADDR_W     = rpa_pkg::ADDR_W;
    localparam int PAGE_SHIFT = rpa_pkg::PAGE_SHIFT;
    localparam int CFG_W      = rpa_pkg::CFG_W;
    localparam int PA_W       = rpa_pkg::PA_W;
    localparam int CNT_OUT_W  = rpa_pkg::CNT_OUT_W;
    localparam logic [CNT_OUT_W-1:0] COUNT_MAX = '1;
    localparam logic [CNT_OUT_W-1:0] COUNT_ONE = CNT_OUT_W'(1);
    localparam logic [CFG_W-1:0] MEM_TOP = 27'd67108864;

    typedef struct {
        logic [2:0]        opcode;
        logic [ADDR_W-1:0] address;
    } page_req_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [PA_W-1:0]      page_address;
        logic [CNT_OUT_W-1:0] ref_count;
        logic                 page_freed;
    } page_reply_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_index = rpa_pkg::CFG_KERNEL_END;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [2:0]           s_opcode = rpa_pkg::OP_ALLOC;
    logic [ADDR_W-1:0]    s_address = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [2:0]           m_status;
    logic [PA_W-1:0]      m_page_address;
    logic [CNT_OUT_W-1:0] m_ref_count;
    logic                 m_page_freed;

    // Mirror of the allocator state
    logic [13:0]          free_pages [NUM_PAGES];
    int unsigned          free_depth = 0;
    logic [CNT_OUT_W-1:0] page_refs [NUM_PAGES];
    logic [CFG_W-1:0]     kernel_end_cfg = rpa_pkg::KERNEL_END_RST;
    logic [CFG_W-1:0]     phys_top_cfg = rpa_pkg::PHYS_TOP_RST;

    page_req_t   page_ops [$];
    page_reply_t pending_replies [$];
    int          page_pool [POOL_SIZE];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;

    refcounted_page_allocator dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_address      (s_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_page_address (m_page_address),
        .m_ref_count    (m_ref_count),
        .m_page_freed   (m_page_freed)
    );

    always #1 aclk = ~aclk;

    // Push a page number unless the free stack is full
    function automatic bit push_free_page(logic [13:0] page);
        if (free_depth >= NUM_PAGES) return 1'b0;
        free_pages[free_depth] = page;
        free_depth++;
        return 1'b1;
    endfunction

    // Apply one operation to the mirror and return the reply it produces
    function automatic page_reply_t predict_page_op(logic [2:0] op,
                                                    logic [ADDR_W-1:0] addr);
        page_reply_t r;
        logic [13:0] page;
        logic [CNT_OUT_W-1:0] cnt;
        bit in_range;
        r = '0;
        page = addr[PAGE_SHIFT +: 14];
        in_range = (addr < phys_top_cfg) && (addr[ADDR_W-1:PAGE_SHIFT] < NUM_PAGES);
        if (op == rpa_pkg::OP_ALLOC) begin
            if (free_depth == 0) begin
                r.status = rpa_pkg::ST_EMPTY;
            end else begin
                free_depth--;
                page = free_pages[free_depth];
                page_refs[page] = COUNT_ONE;
                r.page_address = {page, 12'd0};
                r.ref_count = COUNT_ONE;
            end
            return r;
        end
        if (op > rpa_pkg::OP_QUERY) return r;
        if (!in_range) begin
            r.status = rpa_pkg::ST_RANGE;
            return r;
        end
        cnt = page_refs[page];
        r.ref_count = cnt;
        case (op)
            rpa_pkg::OP_FREE: begin
                if (addr[PAGE_SHIFT-1:0] != 0) begin
                    r.status = rpa_pkg::ST_MISALIGNED;
                end else if (addr < kernel_end_cfg) begin
                    r.status = rpa_pkg::ST_RANGE;
                end else if (cnt > COUNT_ONE) begin
                    page_refs[page] = cnt - 1'b1;
                    r.ref_count = cnt - 1'b1;
                end else if (push_free_page(page)) begin
                    r.page_freed = 1'b1;
                end else begin
                    r.status = rpa_pkg::ST_SATURATED;
                end
            end
            rpa_pkg::OP_INCREF: begin
                if (cnt == COUNT_MAX) begin
                    r.status = rpa_pkg::ST_SATURATED;
                end else begin
                    page_refs[page] = cnt + 1'b1;
                    r.ref_count = cnt + 1'b1;
                end
            end
            rpa_pkg::OP_DECREF: begin
                if (cnt == '0) begin
                    r.status = rpa_pkg::ST_UNDERFLOW;
                end else begin
                    cnt = cnt - 1'b1;
                    page_refs[page] = cnt;
                    r.ref_count = cnt;
                    // Reaching zero returns the page, subject to the free checks
                    if (cnt != '0) begin
                        r.status = rpa_pkg::ST_OK;
                    end else if (addr[PAGE_SHIFT-1:0] != 0) begin
                        r.status = rpa_pkg::ST_MISALIGNED;
                    end else if (addr < kernel_end_cfg) begin
                        r.status = rpa_pkg::ST_RANGE;
                    end else if (push_free_page(page)) begin
                        r.page_freed = 1'b1;
                    end else begin
                        r.status = rpa_pkg::ST_SATURATED;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(string fname, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
            errors++;
        end
    endtask

    task automatic queue_op(logic [2:0] op, logic [ADDR_W-1:0] addr);
        page_req_t req;
        req.opcode = op;
        req.address = addr;
        page_ops.push_back(req);
    endtask

    // Write one register and track it in the mirror; the task does not wait for the block to be idle
    task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        if (idx == rpa_pkg::CFG_PHYS_TOP) phys_top_cfg = value;
        else kernel_end_cfg = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Wait until every item is taken and every reply has come back
    task automatic wait_drained();
        do @(posedge aclk);
        while (page_ops.size() != 0 || s_valid || pending_replies.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Collect pages around the register boundaries and the page range, plus four random ones
    task automatic build_pool();
        int ke_page;
        int top_page;
        ke_page = int'(kernel_end_cfg >> PAGE_SHIFT);
        top_page = int'(phys_top_cfg >> PAGE_SHIFT);
        page_pool[0] = 0;
        page_pool[1] = NUM_PAGES - 1;
        page_pool[2] = NUM_PAGES;
        page_pool[3] = (ke_page > 0) ? ke_page - 1 : 0;
        page_pool[4] = ke_page;
        page_pool[5] = ke_page + 1;
        page_pool[6] = (top_page > 0) ? top_page - 1 : 0;
        page_pool[7] = top_page;
        for (int i = 8; i < POOL_SIZE; i++) page_pool[i] = $urandom_range(0, NUM_PAGES - 1);
    endtask

    function automatic logic [ADDR_W-1:0] pick_address();
        int unsigned roll;
        logic [ADDR_W-1:0] base;
        roll = $urandom_range(0, 99);
        base = ADDR_W'(page_pool[$urandom_range(0, POOL_SIZE - 1)]) << PAGE_SHIFT;
        if (roll < 80) return base;
        if (roll < 88) return base | ADDR_W'($urandom_range(1, 4095));
        if (roll < 94) return $urandom();
        return ADDR_W'(phys_top_cfg) - ADDR_W'($urandom_range(0, 8));
    endfunction

    // Random operations on the pool, with one optional saturation burst
    task automatic queue_random_ops(int unsigned count, bit with_burst);
        int unsigned roll;
        int unsigned burst_at;
        logic [ADDR_W-1:0] hot;
        burst_at = with_burst ? $urandom_range(0, count - 1) : count;
        for (int unsigned i = 0; i < count; i++) begin
            if (i == burst_at) begin
                hot = ADDR_W'(page_pool[$urandom_range(0, POOL_SIZE - 2)]) << PAGE_SHIFT;
                repeat (256) queue_op(rpa_pkg::OP_INCREF, hot);
                queue_op(rpa_pkg::OP_FREE, hot);
                queue_op(rpa_pkg::OP_DECREF, hot);
                queue_op(rpa_pkg::OP_QUERY, hot);
            end
            roll = $urandom_range(0, 99);
            if (roll < 18) queue_op(rpa_pkg::OP_ALLOC, $urandom());
            else if (roll < 38) queue_op(rpa_pkg::OP_FREE, pick_address());
            else if (roll < 62) queue_op(rpa_pkg::OP_INCREF, pick_address());
            else if (roll < 82) queue_op(rpa_pkg::OP_DECREF, pick_address());
            else if (roll < 95) queue_op(rpa_pkg::OP_QUERY, pick_address());
            else queue_op(3'(rpa_pkg::OP_QUERY + $urandom_range(1, 3)), pick_address());
        end
    endtask

    // Sender: present items from the queue, with a random gap before each
    always @(posedge aclk) begin
        int unsigned gap;
        page_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            gap = send_gap;
            if (s_valid && s_ready) begin
                pending_replies.push_back(predict_page_op(s_opcode, s_address));
                if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
                gap = send_calm ? 0 : $urandom_range(0, 3);
            end
            // Hold the item until it is taken
            if (!s_valid || s_ready) begin
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    send_gap <= gap - 1;
                end else if (page_ops.size() != 0) begin
                    req = page_ops.pop_front();
                    s_valid <= 1'b1;
                    s_opcode <= req.opcode;
                    s_address <= req.address;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each reply against the oldest prediction, stall at random
    always @(posedge aclk) begin
        int unsigned stall;
        page_reply_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall <= 0;
        end else begin
            stall = recv_stall;
            if (m_valid && m_ready) begin
                if (pending_replies.size() == 0) begin
                    $display("%0t: reply with no item outstanding: expected none, actual status %0d",
                             $time, m_status);
                    errors++;
                end else begin
                    want = pending_replies.pop_front();
                    compare_field("status", 32'(want.status), 32'(m_status));
                    compare_field("page_address", 32'(want.page_address),
                                  32'(m_page_address));
                    compare_field("ref_count", 32'(want.ref_count), 32'(m_ref_count));
                    compare_field("page_freed", 32'(want.page_freed), 32'(m_page_freed));
                end
                if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
                stall = recv_calm ? 0 : $urandom_range(0, 3);
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                recv_stall <= stall - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int unsigned spare_page;
        foreach (page_refs[i]) page_refs[i] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        write_reg(rpa_pkg::CFG_KERNEL_END, rpa_pkg::KERNEL_END_RST);
        write_reg(rpa_pkg::CFG_PHYS_TOP, rpa_pkg::PHYS_TOP_RST);

        // Directed: empty list, underflow, push and pop, alignment, range, unknown codes
        queue_op(rpa_pkg::OP_ALLOC, 32'hFFFF_FFFF);
        queue_op(rpa_pkg::OP_QUERY, 32'h0000_0000);
        queue_op(rpa_pkg::OP_DECREF, 32'h0000_5000);
        queue_op(rpa_pkg::OP_INCREF, 32'h0000_5000);
        queue_op(rpa_pkg::OP_FREE, 32'h0000_5000);
        queue_op(rpa_pkg::OP_ALLOC, 32'h0000_0000);
        queue_op(rpa_pkg::OP_INCREF, 32'h03FF_F000);
        queue_op(rpa_pkg::OP_FREE, 32'h0000_5001);
        queue_op(rpa_pkg::OP_FREE, 32'h0400_0000);
        queue_op(rpa_pkg::OP_QUERY, 32'hFFFF_FFFF);
        queue_op(rpa_pkg::OP_INCREF, 32'h0000_5000);
        queue_op(rpa_pkg::OP_FREE, 32'h0000_5000);
        queue_op(rpa_pkg::OP_DECREF, 32'h0000_5000);
        queue_op(rpa_pkg::OP_INCREF, 32'h0000_6FFF);
        queue_op(rpa_pkg::OP_DECREF, 32'h0000_6FFF);
        queue_op(rpa_pkg::OP_FREE, 32'h0000_0000);
        queue_op(rpa_pkg::OP_ALLOC, 32'h0000_0000);
        queue_op(3'(rpa_pkg::OP_QUERY + 1), 32'hFFFF_FFFF);
        queue_op(3'(rpa_pkg::OP_QUERY + 2), 32'h0000_0000);
        queue_op(3'(rpa_pkg::OP_QUERY + 3), 32'hFFFF_FFFF);
        queue_op(rpa_pkg::OP_QUERY, 32'h03FF_FFFF);
        queue_op(rpa_pkg::OP_DECREF, 32'h03FF_F000);
        queue_op(rpa_pkg::OP_ALLOC, 32'h0000_0000);
        queue_op(rpa_pkg::OP_ALLOC, 32'h0000_0000);
        queue_op(rpa_pkg::OP_ALLOC, 32'h0000_0000);
        build_pool();
        queue_random_ops(280, 1'b1);
        wait_drained();

        // Kernel end in the middle, top not page aligned
        write_reg(rpa_pkg::CFG_KERNEL_END, 27'h010_0000);
        write_reg(rpa_pkg::CFG_PHYS_TOP, 27'h300_0800);
        queue_op(rpa_pkg::OP_INCREF, 32'h000F_F000);
        queue_op(rpa_pkg::OP_DECREF, 32'h000F_F000);
        queue_op(rpa_pkg::OP_FREE, 32'h000F_F000);
        queue_op(rpa_pkg::OP_FREE, 32'h0010_0000);
        queue_op(rpa_pkg::OP_DECREF, 32'h0010_0000);
        queue_op(rpa_pkg::OP_QUERY, 32'h0300_0FFF);
        queue_op(rpa_pkg::OP_QUERY, 32'h0300_07FF);
        build_pool();
        queue_random_ops(280, 1'b1);
        wait_drained();

        // Extremes: nothing may be freed and nothing is in range
        write_reg(rpa_pkg::CFG_KERNEL_END, MEM_TOP);
        write_reg(rpa_pkg::CFG_PHYS_TOP, 27'd0);
        build_pool();
        queue_random_ops(80, 1'b0);
        wait_drained();

        // Random boundaries
        write_reg(rpa_pkg::CFG_KERNEL_END, CFG_W'($urandom_range(0, 27'h100_0000)));
        write_reg(rpa_pkg::CFG_PHYS_TOP, CFG_W'($urandom_range(27'h200_0000, MEM_TOP)));
        build_pool();
        queue_random_ops(160, 1'b0);
        wait_drained();

        // Push an unreferenced page and walk it through its count
        write_reg(rpa_pkg::CFG_KERNEL_END, rpa_pkg::KERNEL_END_RST);
        write_reg(rpa_pkg::CFG_PHYS_TOP, MEM_TOP);
        spare_page = 0;
        for (int unsigned p = 0; p < NUM_PAGES; p++) begin
            if (page_refs[p] == '0) begin
                spare_page = p;
                break;
            end
        end
        queue_op(rpa_pkg::OP_FREE, ADDR_W'(spare_page) << PAGE_SHIFT);
        queue_op(rpa_pkg::OP_INCREF, ADDR_W'(spare_page) << PAGE_SHIFT);
        queue_op(rpa_pkg::OP_DECREF, ADDR_W'(spare_page) << PAGE_SHIFT);
        queue_op(rpa_pkg::OP_INCREF, ADDR_W'(spare_page) << PAGE_SHIFT);
        queue_op(rpa_pkg::OP_FREE, ADDR_W'(spare_page) << PAGE_SHIFT);
        repeat (3) queue_op(rpa_pkg::OP_ALLOC, $urandom());
        queue_op(rpa_pkg::OP_QUERY, ADDR_W'(spare_page) << PAGE_SHIFT);
        wait_drained();

        repeat (8) @(posedge aclk);
        if (errors == 0 && pending_replies.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
